/* hw/rtl/rgbyuv_pkg.sv */
package rgbyuv_pkg;

    localparam int CFG_W = 13;
    localparam int PIX_W = 8;
    localparam int LIDX_W = 24;
    localparam int CIDX_W = 22;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_COEF_FRACTION_BITS = 16;

    // BT.709 weights in units of 1e-4
    localparam int Y_R = 2126;
    localparam int Y_G = 7152;
    localparam int Y_B = 722;
    localparam int CB_R = -1146;
    localparam int CB_G = -3854;
    localparam int CB_B = 5000;
    localparam int CR_R = 5000;
    localparam int CR_G = -4542;
    localparam int CR_B = -458;
    localparam int CHROMA_OFFSET = 128;

    typedef struct packed {
        logic [LIDX_W-1:0] luma_index;
        logic [CIDX_W-1:0] chroma_index;
        logic              chroma_write;
        logic              frame_end;
    } pos_t;

    // weight scaled by 2^frac, rounded half away from zero
    function automatic longint coef(int ten_thousandths, int frac);
        longint mag;
        longint q;
        mag = (ten_thousandths < 0) ? -longint'(ten_thousandths) : longint'(ten_thousandths);
        q = (mag * (64'sd1 <<< frac) + 64'sd5000) / 64'sd10000;
        return (ten_thousandths < 0) ? -q : q;
    endfunction

endpackage

/* hw/rtl/rgbyuv_matrix.sv */
module rgbyuv_matrix #(
    parameter int COEF_FRACTION_BITS = rgbyuv_pkg::DEF_COEF_FRACTION_BITS,
    parameter int WEIGHT_R = rgbyuv_pkg::Y_R,
    parameter int WEIGHT_G = rgbyuv_pkg::Y_G,
    parameter int WEIGHT_B = rgbyuv_pkg::Y_B,
    parameter int OFFSET = 0
) (
    input  logic [rgbyuv_pkg::PIX_W-1:0] red,
    input  logic [rgbyuv_pkg::PIX_W-1:0] green,
    input  logic [rgbyuv_pkg::PIX_W-1:0] blue,
    output logic [rgbyuv_pkg::PIX_W-1:0] result
);

    localparam int COEF_W = COEF_FRACTION_BITS + 2;
    localparam int SUM_W = COEF_W + rgbyuv_pkg::PIX_W + 3;
    localparam longint KR = rgbyuv_pkg::coef(WEIGHT_R, COEF_FRACTION_BITS);
    localparam longint KG = rgbyuv_pkg::coef(WEIGHT_G, COEF_FRACTION_BITS);
    localparam longint KB = rgbyuv_pkg::coef(WEIGHT_B, COEF_FRACTION_BITS);

    localparam logic signed [COEF_W-1:0] KR_C = COEF_W'(KR);
    localparam logic signed [COEF_W-1:0] KG_C = COEF_W'(KG);
    localparam logic signed [COEF_W-1:0] KB_C = COEF_W'(KB);

    logic signed [SUM_W-1:0] kr_x;
    logic signed [SUM_W-1:0] kg_x;
    logic signed [SUM_W-1:0] kb_x;
    logic signed [SUM_W-1:0] r_x;
    logic signed [SUM_W-1:0] g_x;
    logic signed [SUM_W-1:0] b_x;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] level;

    assign kr_x = SUM_W'(KR_C);
    assign kg_x = SUM_W'(KG_C);
    assign kb_x = SUM_W'(KB_C);
    assign r_x = $signed(SUM_W'(red));
    assign g_x = $signed(SUM_W'(green));
    assign b_x = $signed(SUM_W'(blue));

    assign sum = kr_x * r_x + kg_x * g_x + kb_x * b_x;
    // arithmetic shift floors toward minus infinity
    assign level = (sum >>> COEF_FRACTION_BITS) + $signed(SUM_W'(OFFSET));

    always_comb begin
        if (level < 0) begin
            result = '0;
        end else if (level > $signed(SUM_W'(255))) begin
            result = '1;
        end else begin
            result = level[rgbyuv_pkg::PIX_W-1:0];
        end
    end

endmodule

/* hw/rtl/rgbyuv_position.sv */
module rgbyuv_position #(
    parameter int MAX_WIDTH = rgbyuv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbyuv_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [rgbyuv_pkg::CFG_W-1:0] frame_width,
    input  logic [rgbyuv_pkg::CFG_W-1:0] frame_height,
    output rgbyuv_pkg::pos_t             pos
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PROD_W = ROW_W + rgbyuv_pkg::CFG_W;

    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;
    logic [rgbyuv_pkg::LIDX_W-1:0] luma_position_reg;
    logic [rgbyuv_pkg::LIDX_W-1:0] luma_position_next;

    logic [rgbyuv_pkg::CFG_W-1:0] eff_width;
    logic [rgbyuv_pkg::CFG_W-1:0] eff_height;
    logic row_end;
    logic last_row;
    logic [ROW_W-1:0] row_half;
    logic [rgbyuv_pkg::CFG_W-1:0] width_half;
    logic [PROD_W-1:0] prod;

    always_comb begin
        if (frame_width == '0) begin
            eff_width = rgbyuv_pkg::CFG_W'(1);
        end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
            eff_width = rgbyuv_pkg::CFG_W'(MAX_WIDTH);
        end else begin
            eff_width = frame_width;
        end
        if (frame_height == '0) begin
            eff_height = rgbyuv_pkg::CFG_W'(1);
        end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
            eff_height = rgbyuv_pkg::CFG_W'(MAX_HEIGHT);
        end else begin
            eff_height = frame_height;
        end
    end

    assign row_end = (32'(column_count_reg) + 32'd1) >= 32'(eff_width);
    assign last_row = (32'(row_count_reg) + 32'd1) >= 32'(eff_height);

    assign row_half = row_count_reg >> 1;
    assign width_half = eff_width >> 1;
    assign prod = PROD_W'(row_half) * PROD_W'(width_half);

    assign pos.luma_index = luma_position_reg;
    assign pos.chroma_index = rgbyuv_pkg::CIDX_W'(prod)
                              + rgbyuv_pkg::CIDX_W'(column_count_reg >> 1);
    assign pos.chroma_write = !column_count_reg[0] && !row_count_reg[0];
    assign pos.frame_end = row_end && last_row;

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next = row_count_reg;
        luma_position_next = luma_position_reg;
        if (advance) begin
            if (row_end && last_row) begin
                column_count_next = '0;
                row_count_next = '0;
                luma_position_next = '0;
            end else begin
                luma_position_next = luma_position_reg + rgbyuv_pkg::LIDX_W'(1);
                if (row_end) begin
                    column_count_next = '0;
                    row_count_next = row_count_reg + ROW_W'(1);
                end else begin
                    column_count_next = column_count_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg <= '0;
            luma_position_reg <= '0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg <= row_count_next;
            luma_position_reg <= luma_position_next;
        end
    end

endmodule

/* hw/rtl/rgb_to_yuv420_converter.sv */
// Channel | Dir | Signals                          | Contents
// s_      | in  | s_tvalid s_tready s_tdata[23:0]  | red, green, blue
// m_      | out | m_tvalid m_tready m_tdata[71:0]  | luma, luma_index, chroma_blue,
//         |     | m_tuser m_tlast                  | chroma_red, chroma_index; chroma_write;
//         |     |                                  | frame_end
// cfg_    | in  | cfg_valid cfg_ready cfg_addr     | 0 frame_width, 1 frame_height
//         |     | cfg_data[12:0]                   |
// One item per clock while m_tready holds; the input stage holds pixel and position,
// and the color matrix sits between it and the output register.
// aresetn (synchronous) clears counters, valid flags and frame size to 1920x1080.
// A stall on m_tready fills both stages before s_tready drops; no item is lost.
module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH = rgbyuv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbyuv_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_FRACTION_BITS = rgbyuv_pkg::DEF_COEF_FRACTION_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // red, green, blue
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [71:0]                       m_tdata,   // luma, luma_index, chroma_blue,
                                                         // chroma_red, chroma_index, pad
    output logic                              m_tuser,   // chroma_write
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgbyuv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rgbyuv_pkg::CFG_W-1:0]      cfg_data
);

    localparam int PW = rgbyuv_pkg::PIX_W;

    logic [rgbyuv_pkg::CFG_W-1:0] frame_width_reg;
    logic [rgbyuv_pkg::CFG_W-1:0] frame_height_reg;

    logic in_accept;
    logic out_advance;
    rgbyuv_pkg::pos_t pos;

    logic             s1_valid_reg;
    logic [23:0]      s1_pixel_reg;
    rgbyuv_pkg::pos_t s1_pos_reg;

    logic [PW-1:0] luma;
    logic [PW-1:0] chroma_blue;
    logic [PW-1:0] chroma_red;

    logic             out_valid_reg;
    logic [PW-1:0]    out_luma_reg;
    logic [PW-1:0]    out_cb_reg;
    logic [PW-1:0]    out_cr_reg;
    rgbyuv_pkg::pos_t out_pos_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= rgbyuv_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= rgbyuv_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                rgbyuv_pkg::REG_FRAME_WIDTH: frame_width_reg <= cfg_data;
                rgbyuv_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_advance;
    assign in_accept = s_tvalid && s_tready;

    rgbyuv_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (in_accept),
        .frame_width (frame_width_reg),
        .frame_height(frame_height_reg),
        .pos         (pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (out_advance) begin
            s1_valid_reg <= 1'b0;
        end
        if (in_accept) begin
            s1_pixel_reg <= s_tdata;
            s1_pos_reg <= pos;
        end
    end

    rgbyuv_matrix #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS),
        .WEIGHT_R(rgbyuv_pkg::Y_R),
        .WEIGHT_G(rgbyuv_pkg::Y_G),
        .WEIGHT_B(rgbyuv_pkg::Y_B),
        .OFFSET  (0)
    ) u_luma (
        .red   (s1_pixel_reg[7:0]),
        .green (s1_pixel_reg[15:8]),
        .blue  (s1_pixel_reg[23:16]),
        .result(luma)
    );

    rgbyuv_matrix #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS),
        .WEIGHT_R(rgbyuv_pkg::CB_R),
        .WEIGHT_G(rgbyuv_pkg::CB_G),
        .WEIGHT_B(rgbyuv_pkg::CB_B),
        .OFFSET  (rgbyuv_pkg::CHROMA_OFFSET)
    ) u_cb (
        .red   (s1_pixel_reg[7:0]),
        .green (s1_pixel_reg[15:8]),
        .blue  (s1_pixel_reg[23:16]),
        .result(chroma_blue)
    );

    rgbyuv_matrix #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS),
        .WEIGHT_R(rgbyuv_pkg::CR_R),
        .WEIGHT_G(rgbyuv_pkg::CR_G),
        .WEIGHT_B(rgbyuv_pkg::CR_B),
        .OFFSET  (rgbyuv_pkg::CHROMA_OFFSET)
    ) u_cr (
        .red   (s1_pixel_reg[7:0]),
        .green (s1_pixel_reg[15:8]),
        .blue  (s1_pixel_reg[23:16]),
        .result(chroma_red)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= s1_valid_reg;
        end
        if (out_advance && s1_valid_reg) begin
            out_luma_reg <= luma;
            out_cb_reg <= chroma_blue;
            out_cr_reg <= chroma_red;
            out_pos_reg <= s1_pos_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_pos_reg.chroma_index, out_cr_reg, out_cb_reg,
                      out_pos_reg.luma_index, out_luma_reg};
    assign m_tuser = out_pos_reg.chroma_write;
    assign m_tlast = out_pos_reg.frame_end;

endmodule
